// ===== hw/rtl/qrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, types and step functions of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 16;
    localparam int ROOT_W    = 40;
    localparam int DISC_W    = 34;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int RAD_W     = 2 * DISC_W - 2;
    localparam int SQ_STEPS  = RAD_W / 2;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int SQ_REM_W  = SQ_ROOT_W + 3;
    localparam int NUM_W     = 34;
    localparam int DEN_W     = COEF_W + 1;
    localparam int N_STAGES  = 3 + SQ_STEPS + NUM_W + 1;

    typedef enum logic [1:0] {
        KIND_TWO_REAL   = 2'd0,
        KIND_REPEATED   = 2'd1,
        KIND_COMPLEX    = 2'd2,
        KIND_DEGENERATE = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [DISC_W-1:0] d;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0]     rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
        t_side                side;
    } t_sq;

    typedef struct packed {
        logic [NUM_W-1:0]         n1;
        logic [NUM_W-1:0]         n2;
        logic [DEN_W-1:0]         r1;
        logic [DEN_W-1:0]         r2;
        logic [DEN_W-1:0]         den;
        logic                     neg1;
        logic                     neg2;
        t_kind                    kind;
        logic signed [DISC_W-1:0] d;
    } t_dv;

    // one digit pair of the square root
    function automatic t_sq sq_step(input t_sq x);
        t_sq                  y;
        logic [SQ_REM_W-1:0]  rm;
        logic [SQ_REM_W-1:0]  trial;
        y     = x;
        rm    = {x.rem[SQ_REM_W-3:0], x.rad[RAD_W-1 -: 2]};
        trial = {1'b0, x.root, 2'b01};
        y.root = {x.root[SQ_ROOT_W-2:0], 1'b0};
        if (rm >= trial) begin
            rm        = rm - trial;
            y.root[0] = 1'b1;
        end
        y.rem = rm;
        y.rad = {x.rad[RAD_W-3:0], 2'b00};
        return y;
    endfunction

    // one quotient bit of both divisions
    function automatic t_dv dv_step(input t_dv x);
        t_dv              y;
        logic [DEN_W:0]   t1;
        logic [DEN_W:0]   t2;
        y  = x;
        t1 = {x.r1, x.n1[NUM_W-1]};
        t2 = {x.r2, x.n2[NUM_W-1]};
        y.n1 = {x.n1[NUM_W-2:0], 1'b0};
        y.n2 = {x.n2[NUM_W-2:0], 1'b0};
        if (t1 >= {1'b0, x.den}) begin
            t1      = t1 - {1'b0, x.den};
            y.n1[0] = 1'b1;
        end
        if (t2 >= {1'b0, x.den}) begin
            t2      = t2 - {1'b0, x.den};
            y.n2[0] = 1'b1;
        end
        y.r1 = t1[DEN_W-1:0];
        y.r2 = t2[DEN_W-1:0];
        return y;
    endfunction

endpackage

// ===== hw/rtl/quadratic_root_solver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Pipelined quadratic solver: discriminant, digit-pair square root and two
// bit-per-stage truncating divisions by 2a.
//
//   channel  handshake           fields
//   in       i_valid / o_ready   i_coef_a, i_coef_b, i_coef_c
//   out      o_valid / i_ready   o_root_kind, o_first_value, o_second_value,
//                                o_discriminant
//
// one item per cycle while the output is not stalled: products and discriminant
// registers, 33 square root stages (one digit pair each), a setup register,
// 34 divider stages (one quotient bit each) and an output register
// synchronous active-low reset clears the valid bits only
// the whole pipeline holds while a result waits, bubbles included
// ----------------------------------------------------------------------------
module quadratic_root_solver_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [qrs_pkg::COEF_W-1:0]    i_coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]    i_coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]    i_coef_c,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_root_kind,
    output logic signed [qrs_pkg::ROOT_W-1:0]    o_first_value,
    output logic signed [qrs_pkg::ROOT_W-1:0]    o_second_value,
    output logic signed [qrs_pkg::DISC_W-1:0]    o_discriminant
);

    localparam int NS = qrs_pkg::N_STAGES;
    localparam int SQ = qrs_pkg::SQ_STEPS;
    localparam int NW = qrs_pkg::NUM_W;

    logic [NS-1:0]                        r_vld;
    logic                                 w_en;
    logic signed [qrs_pkg::COEF_W-1:0]    r_a0;
    logic signed [qrs_pkg::COEF_W-1:0]    r_b0;
    logic signed [qrs_pkg::PROD_W-1:0]    r_bb;
    logic signed [qrs_pkg::PROD_W-1:0]    r_ac;
    qrs_pkg::t_side                       r_side;
    qrs_pkg::t_sq                         r_sq [SQ];
    qrs_pkg::t_dv                         r_dv [NW+1];
    qrs_pkg::t_kind                       r_kind;
    logic signed [qrs_pkg::ROOT_W-1:0]    r_first;
    logic signed [qrs_pkg::ROOT_W-1:0]    r_second;
    logic signed [qrs_pkg::DISC_W-1:0]    r_disc;

    qrs_pkg::t_side                       n_side;
    qrs_pkg::t_sq                         n_sq0;
    qrs_pkg::t_dv                         n_prep;
    logic [qrs_pkg::DISC_W-1:0]           w_dmag;
    logic signed [qrs_pkg::NUM_W+1:0]     w_bs;
    logic signed [qrs_pkg::NUM_W+1:0]     w_s;
    logic signed [qrs_pkg::NUM_W+1:0]     w_n1;
    logic signed [qrs_pkg::NUM_W+1:0]     w_n2;
    logic signed [qrs_pkg::DEN_W-1:0]     w_a2;
    logic signed [qrs_pkg::ROOT_W-1:0]    w_q1;
    logic signed [qrs_pkg::ROOT_W-1:0]    w_q2;
    qrs_pkg::t_side                       w_sd;

    assign w_en    = !r_vld[NS-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NS-1];

    // discriminant and square root setup
    always_comb begin
        n_side.a = r_a0;
        n_side.b = r_b0;
        n_side.d = qrs_pkg::DISC_W'(r_bb) - (qrs_pkg::DISC_W'(r_ac) <<< 2);
        w_dmag   = r_side.d[qrs_pkg::DISC_W-1] ? qrs_pkg::DISC_W'(-r_side.d)
                                               : qrs_pkg::DISC_W'(r_side.d);
        n_sq0.rad  = {w_dmag, {(2*qrs_pkg::FRAC_BITS){1'b0}}};
        n_sq0.rem  = '0;
        n_sq0.root = '0;
        n_sq0.side = r_side;
    end

    // classification and divider setup
    always_comb begin
        w_sd = r_sq[SQ-1].side;
        w_bs = -((qrs_pkg::NUM_W+2)'(w_sd.b) <<< qrs_pkg::FRAC_BITS);
        w_s  = (qrs_pkg::NUM_W+2)'({1'b0, r_sq[SQ-1].root});
        w_a2 = qrs_pkg::DEN_W'(w_sd.a) <<< 1;
        if (w_sd.a == '0) begin
            n_prep.kind = qrs_pkg::KIND_DEGENERATE;
        end else if (w_sd.d < 0) begin
            n_prep.kind = qrs_pkg::KIND_COMPLEX;
        end else if (w_sd.d == '0) begin
            n_prep.kind = qrs_pkg::KIND_REPEATED;
        end else begin
            n_prep.kind = qrs_pkg::KIND_TWO_REAL;
        end
        w_n1 = (n_prep.kind == qrs_pkg::KIND_TWO_REAL) ? w_bs + w_s : w_bs;
        case (n_prep.kind)
            qrs_pkg::KIND_TWO_REAL: w_n2 = w_bs - w_s;
            qrs_pkg::KIND_COMPLEX:  w_n2 = w_s;
            default:                w_n2 = w_bs;
        endcase
        n_prep.n1   = w_n1[qrs_pkg::NUM_W+1] ? qrs_pkg::NUM_W'(-w_n1) : qrs_pkg::NUM_W'(w_n1);
        n_prep.n2   = w_n2[qrs_pkg::NUM_W+1] ? qrs_pkg::NUM_W'(-w_n2) : qrs_pkg::NUM_W'(w_n2);
        n_prep.r1   = '0;
        n_prep.r2   = '0;
        n_prep.den  = w_a2[qrs_pkg::DEN_W-1] ? qrs_pkg::DEN_W'(-w_a2) : qrs_pkg::DEN_W'(w_a2);
        n_prep.neg1 = w_n1[qrs_pkg::NUM_W+1] ^ w_sd.a[qrs_pkg::COEF_W-1];
        n_prep.neg2 = w_n2[qrs_pkg::NUM_W+1]
                    ^ ((n_prep.kind != qrs_pkg::KIND_COMPLEX) && w_sd.a[qrs_pkg::COEF_W-1]);
        n_prep.d    = w_sd.d;
    end

    // signed quotients
    always_comb begin
        w_q1 = qrs_pkg::ROOT_W'(r_dv[NW].n1);
        w_q2 = qrs_pkg::ROOT_W'(r_dv[NW].n2);
        if (r_dv[NW].neg1) begin
            w_q1 = -w_q1;
        end
        if (r_dv[NW].neg2) begin
            w_q2 = -w_q2;
        end
        if (r_dv[NW].kind == qrs_pkg::KIND_DEGENERATE) begin
            w_q1 = '0;
            w_q2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a0     <= i_coef_a;
            r_b0     <= i_coef_b;
            r_bb     <= qrs_pkg::PROD_W'(i_coef_b) * qrs_pkg::PROD_W'(i_coef_b);
            r_ac     <= qrs_pkg::PROD_W'(i_coef_a) * qrs_pkg::PROD_W'(i_coef_c);
            r_side   <= n_side;
            r_sq[0]  <= qrs_pkg::sq_step(n_sq0);
            for (int k = 1; k < SQ; k++) begin
                r_sq[k] <= qrs_pkg::sq_step(r_sq[k-1]);
            end
            r_dv[0]  <= n_prep;
            for (int k = 1; k <= NW; k++) begin
                r_dv[k] <= qrs_pkg::dv_step(r_dv[k-1]);
            end
            r_kind   <= r_dv[NW].kind;
            r_first  <= w_q1;
            r_second <= w_q2;
            r_disc   <= r_dv[NW].d;
        end
    end

    assign o_root_kind    = r_kind;
    assign o_first_value  = r_first;
    assign o_second_value = r_second;
    assign o_discriminant = r_disc;

endmodule

// ===== hw/rtl/qrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic [1:0]                           o_root_kind,
    input  logic signed [qrs_pkg::ROOT_W-1:0]    o_first_value,
    input  logic signed [qrs_pkg::ROOT_W-1:0]    o_second_value,
    input  logic signed [qrs_pkg::DISC_W-1:0]    o_discriminant
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_first_value) && $stable(o_second_value))
        else $error("result item changed while stalled");

    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == qrs_pkg::KIND_DEGENERATE
            |-> o_first_value == '0 && o_second_value == '0)
        else $error("degenerate item with nonzero roots");

    a_repeated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == qrs_pkg::KIND_REPEATED
            |-> o_first_value == o_second_value && o_discriminant == '0)
        else $error("repeated root mismatch");

    a_complex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == qrs_pkg::KIND_COMPLEX
            |-> o_discriminant < 0 && o_second_value >= 0)
        else $error("complex pair with bad sign");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_root_kind    (o_root_kind),
    .o_first_value  (o_first_value),
    .o_second_value (o_second_value),
    .o_discriminant (o_discriminant)
);
